FILE: rtl/core/vrd_pkg.sv
// Package for the video register DMA engine: command codes, register offsets,
// field widths and the structs passed between the core modules.
// No dependencies.
package vrd_pkg;

  // Field widths.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned OffW      = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SrcW      = 25;
  localparam int unsigned DstW      = 25;
  localparam int unsigned WaddrW    = 21;
  localparam int unsigned LeftW     = 23;
  localparam int unsigned LenW      = 21;
  localparam int unsigned RomLimitW = 26;

  // Register offsets and bit positions used by the copy engine and the top level.
  localparam logic [OffW-1:0] StartOffset = 8'hA8;
  localparam logic [4:0]      ParamBase   = 5'b10100;  // offsets 0xa0..0xa7
  localparam int unsigned     StartBit    = 5;
  localparam int unsigned     LenHighW    = 5;         // low bits of 0xa8
  localparam logic [OffW-1:0] FirstRegOff = 8'h02;     // 0 and 1 read as zero

  // Parameter byte slots, offset minus 0xa0.
  localparam int unsigned SrcB0 = 0;
  localparam int unsigned SrcB1 = 1;
  localparam int unsigned SrcB2 = 2;
  localparam int unsigned DstB0 = 3;
  localparam int unsigned DstB1 = 4;
  localparam int unsigned DstB2 = 5;
  localparam int unsigned LenB0 = 6;
  localparam int unsigned LenB1 = 7;
  localparam int unsigned ParamCount = 8;

  // Command codes of an input transaction.
  typedef enum logic [CmdW-1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdByte  = 2'd2
  } cmd_e;

  // One input transaction.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [OffW-1:0]  reg_offset;
    logic [ByteW-1:0] reg_data;
  } item_t;

  // Copy engine response for one accepted transaction.
  typedef struct packed {
    logic              fetch_valid;
    logic [SrcW-1:0]   fetch_address;
    logic              write_valid;
    logic [WaddrW-1:0] write_address;
    logic [ByteW-1:0]  write_data;
    logic              busy;
    logic              abort;
  } dma_rsp_t;

endpackage

FILE: rtl/core/vrd_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on vrd_pkg for the field widths.
interface vrd_req_if
  import vrd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [OffW-1:0]  reg_offset;
  logic [ByteW-1:0] reg_data;

  modport source (output valid, cmd, reg_offset, reg_data, input ready);
  modport sink   (input valid, cmd, reg_offset, reg_data, output ready);
endinterface

interface vrd_rsp_if
  import vrd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  read_data;
  logic              fetch_valid;
  logic [SrcW-1:0]   fetch_address;
  logic              write_valid;
  logic [WaddrW-1:0] write_address;
  logic [ByteW-1:0]  write_data;
  logic              dma_busy;
  logic              dma_abort;

  modport source (output valid, read_data, fetch_valid, fetch_address, write_valid,
                  write_address, write_data, dma_busy, dma_abort, input ready);
  modport sink   (input valid, read_data, fetch_valid, fetch_address, write_valid,
                  write_address, write_data, dma_busy, dma_abort, output ready);
endinterface

FILE: rtl/core/vrd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module vrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/vrd_apb.sv
// APB-style configuration port holding the ROM limit register.
// Depends on vrd_pkg.
module vrd_apb
  import vrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [RomLimitW-1:0] rom_limit_o
);

  logic [RomLimitW-1:0] rom_limit_q, rom_limit_d;
  logic                 sel_limit;

  // Register 0 occupies the first word.
  assign sel_limit = (paddr[2] == 1'b0);
  assign pready    = 1'b1;

  // Write on the access phase.
  always_comb begin
    rom_limit_d = rom_limit_q;
    if (psel && penable && pwrite && sel_limit) begin
      rom_limit_d = pwdata[RomLimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_limit_q <= '0;
    end else begin
      rom_limit_q <= rom_limit_d;
    end
  end

  // Read-back of the limit register.
  assign prdata      = sel_limit ? {{(32 - RomLimitW){1'b0}}, rom_limit_q} : 32'd0;
  assign rom_limit_o = rom_limit_q;

endmodule

FILE: rtl/core/vrd_dma_ctrl.sv
// Copy engine: parameter byte mirror, source/destination pointers, byte count
// and the per-transaction fetch/write decision. Depends on vrd_pkg.
module vrd_dma_ctrl
  import vrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  item_t                item_i,
  input  logic [RomLimitW-1:0] rom_limit_i,
  output logic                 active_o,
  output dma_rsp_t             rsp_o
);

  logic [ByteW-1:0] par_q [ParamCount];
  logic [SrcW-1:0]  src_q, src_d;
  logic [DstW-1:0]  dst_q, dst_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             active_q, active_d;
  logic             par_we;
  logic [LenW-1:0]  len_w;
  cmd_e             cmd;

  assign cmd = cmd_e'(item_i.cmd);

  // Offsets 0xa0..0xa7 are mirrored so that a start sees all of them at once.
  assign par_we = acc_i && (cmd == CmdWrite) && !active_q
                  && (item_i.reg_offset[OffW-1:3] == ParamBase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ParamCount; i++) begin
        par_q[i] <= '0;
      end
    end else if (par_we) begin
      par_q[item_i.reg_offset[2:0]] <= item_i.reg_data;
    end
  end

  assign len_w = {item_i.reg_data[LenHighW-1:0], par_q[LenB1], par_q[LenB0]};

  // Decide the response and the next pointer state for this transaction.
  always_comb begin
    src_d    = src_q;
    dst_d    = dst_q;
    left_d   = left_q;
    active_d = active_q;
    rsp_o    = '0;
    case (cmd)
      CmdWrite: begin
        if (acc_i && !active_q && (item_i.reg_offset == StartOffset)
            && item_i.reg_data[StartBit]) begin
          src_d  = {par_q[SrcB2], par_q[SrcB1], par_q[SrcB0], 1'b0};
          dst_d  = {par_q[DstB2], par_q[DstB1], par_q[DstB0], 1'b0};
          left_d = {(LeftW - 1)'({1'b0, len_w} + (LenW + 1)'(1)), 1'b0};
          if (({1'b0, src_d} < rom_limit_i) && (dst_d[DstW-1:WaddrW] == '0)) begin
            active_d           = 1'b1;
            rsp_o.fetch_valid  = 1'b1;
            rsp_o.fetch_address = src_d;
          end else begin
            rsp_o.abort = 1'b1;
          end
        end
      end
      CmdByte: begin
        if (acc_i && active_q) begin
          rsp_o.write_valid   = 1'b1;
          rsp_o.write_address = dst_q[WaddrW-1:0];
          rsp_o.write_data    = item_i.reg_data;
          src_d  = src_q + SrcW'(1);
          dst_d  = dst_q + DstW'(1);
          left_d = left_q - LeftW'(1);
          if (left_d == '0) begin
            active_d = 1'b0;
          end else if (({1'b0, src_d} < rom_limit_i) && (dst_d[DstW-1:WaddrW] == '0)) begin
            rsp_o.fetch_valid   = 1'b1;
            rsp_o.fetch_address = src_d;
          end else begin
            active_d    = 1'b0;
            rsp_o.abort = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp_o.busy = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q    <= '0;
      dst_q    <= '0;
      left_q   <= '0;
      active_q <= 1'b0;
    end else begin
      src_q    <= src_d;
      dst_q    <= dst_d;
      left_q   <= left_d;
      active_q <= active_d;
    end
  end

  assign active_o = active_q;

`ifndef SYNTHESIS
  // A running copy always has bytes left to move.
  assert property (@(posedge clk_i) disable iff (!rst_ni) active_q |-> (left_q != '0))
    else $error("copy active with zero bytes left");

  // A fetched byte during a copy always produces a character RAM write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && active_q && (cmd == CmdByte)) |-> rsp_o.write_valid)
    else $error("fetched byte dropped during copy");

  // An abort never requests another byte and always ends the copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.abort |-> (!rsp_o.fetch_valid && !active_d))
    else $error("abort with fetch request or copy still running");

  // The pointers move only on a fetched byte or a start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(src_q) && $stable(dst_q) && $stable(left_q))
    else $error("copy state changed without a transaction");
`endif

endmodule

FILE: rtl/core/video_register_dma_engine_top.sv
// A result is valid in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while the response side is ready, set by
// the single output register and the registered read of the register file RAM.
// Reset: control state and the copy engine clear at once; the register file
// entries are tracked by per-entry valid bits and read as zero until written,
// so no clearing pass is needed. Depends on vrd_pkg, vrd_if, vrd_ram, vrd_apb,
// vrd_dma_ctrl.
module video_register_dma_engine_top
  import vrd_pkg::*;
#(
  parameter int unsigned REG_COUNT = 192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vrd_req_if.sink          req_i,
  vrd_rsp_if.source        rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned      AddrW     = $clog2(REG_COUNT);
  localparam logic [OffW:0]    RegCountW = (OffW + 1)'(REG_COUNT);

  item_t                item;
  logic                 acc;
  logic                 in_range;
  logic                 dma_active;
  dma_rsp_t             dma_rsp;
  logic [RomLimitW-1:0] rom_limit;
  logic [AddrW-1:0]     addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [ByteW-1:0]     ram_rdata;
  logic [REG_COUNT-1:0] vld_q, vld_d;
  logic                 out_vld_q, out_vld_d;
  logic                 rd_ok_q;
  dma_rsp_t             rsp_q;

  // Input transaction and handshake.
  assign item.cmd        = req_i.cmd;
  assign item.reg_offset = req_i.reg_offset;
  assign item.reg_data   = req_i.reg_data;
  assign req_i.ready     = !out_vld_q || rsp_o.ready;
  assign acc             = req_i.valid && req_i.ready;

  assign in_range = ({1'b0, item.reg_offset} < RegCountW);
  assign addr     = item.reg_offset[AddrW-1:0];

  // Register file writes are blocked while a copy runs.
  assign ram_we = acc && (cmd_e'(item.cmd) == CmdWrite) && !dma_active && in_range;
  assign ram_re = acc && (cmd_e'(item.cmd) == CmdRead);

  vrd_ram #(
    .WIDTH (ByteW),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (item.reg_data),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // Per-entry written flags stand in for clearing the RAM.
  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[addr] = 1'b1;
    end
  end

  vrd_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rom_limit_o (rom_limit)
  );

  vrd_dma_ctrl u_dma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .item_i      (item),
    .rom_limit_i (rom_limit),
    .active_o    (dma_active),
    .rsp_o       (dma_rsp)
  );

  // Output register occupancy.
  always_comb begin
    out_vld_d = out_vld_q;
    if (acc) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload, captured with the transaction.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q   <= dma_rsp;
      rd_ok_q <= ram_re && in_range && (item.reg_offset >= FirstRegOff) && vld_q[addr];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.read_data     = rd_ok_q ? ram_rdata : '0;
  assign rsp_o.fetch_valid   = rsp_q.fetch_valid;
  assign rsp_o.fetch_address = rsp_q.fetch_address;
  assign rsp_o.write_valid   = rsp_q.write_valid;
  assign rsp_o.write_address = rsp_q.write_address;
  assign rsp_o.write_data    = rsp_q.write_data;
  assign rsp_o.dma_busy      = rsp_q.busy;
  assign rsp_o.dma_abort     = rsp_q.abort;

`ifndef SYNTHESIS
  // A transaction is only taken when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_o.ready) |-> !acc)
    else $error("transaction accepted over a stalled result");

  // The register file is never written during a copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) dma_active |-> !ram_we)
    else $error("register write during copy");

  // A register read and a RAM write never come from the same transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_re && ram_we))
    else $error("read and write issued together");
`endif

endmodule

FILE: tb/tb_video_register_dma_engine_top.sv
// Self-checking testbench for the video register DMA engine top level.
// Depends on vrd_pkg, the vrd_req_if and vrd_rsp_if channel interfaces
// and video_register_dma_engine_top.
module tb_video_register_dma_engine_top
  import vrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned       RegCount     = 192;
  localparam logic [CmdW-1:0]   CmdReserved  = 2'd3;
  localparam logic [2:0]        RomLimitAddr = 3'd0;
  localparam logic [DstW-1:0]   DstBound     = 25'h200000;
  localparam int unsigned       StuckLimit   = 2000;

  // Expected contents of one response transaction.
  typedef struct {
    logic [ByteW-1:0]  read_data;
    logic              fetch_valid;
    logic [SrcW-1:0]   fetch_address;
    logic              write_valid;
    logic [WaddrW-1:0] write_address;
    logic [ByteW-1:0]  write_data;
    logic              dma_busy;
    logic              dma_abort;
  } engine_rsp_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  vrd_req_if req_if ();
  vrd_rsp_if rsp_if ();

  video_register_dma_engine_top #(
    .REG_COUNT(RegCount)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the register file, the copy engine and its configuration.
  logic [ByteW-1:0]     shadow_regs [RegCount];
  logic [SrcW-1:0]      src_ptr  = '0;
  logic [DstW-1:0]      dst_ptr  = '0;
  logic [LeftW-1:0]     left_cnt = '0;
  logic                 copy_on  = 1'b0;
  logic [RomLimitW-1:0] rom_lim  = '0;

  item_t       req_backlog [$];
  engine_rsp_t due_rsp [$];
  logic        req_open   = 1'b0;
  int unsigned taken_cnt  = 0;
  int unsigned stuck_cnt  = 0;
  int unsigned fail_count = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [OffW-1:0] param_off(int unsigned slot);
    return {ParamBase, slot[2:0]};
  endfunction

  function automatic logic [ByteW-1:0] param_byte(int unsigned slot);
    return shadow_regs[param_off(slot)];
  endfunction

  function automatic logic in_bounds();
    return ({1'b0, src_ptr} < rom_lim) && (dst_ptr < DstBound);
  endfunction

  // Advances the shadow engine by one request and returns the response it gives.
  function automatic engine_rsp_t engine_step(logic [CmdW-1:0] cmd, logic [OffW-1:0] off,
                                              logic [ByteW-1:0] data);
    engine_rsp_t r;
    logic [23:0] s_word;
    logic [23:0] d_word;
    logic [LenW-1:0] n_words;
    r = '{default: '0};
    case (cmd)
      CmdRead: begin
        // Offsets 0 and 1 are scanline reads and return zero.
        if (off >= FirstRegOff && off < RegCount) r.read_data = shadow_regs[off];
      end
      CmdWrite: begin
        if (!copy_on && off < RegCount) begin
          shadow_regs[off] = data;
          if (off == StartOffset && data[StartBit]) begin
            s_word = {param_byte(SrcB2), param_byte(SrcB1), param_byte(SrcB0)};
            d_word = {param_byte(DstB2), param_byte(DstB1), param_byte(DstB0)};
            n_words = {shadow_regs[StartOffset][LenHighW-1:0], param_byte(LenB1),
                       param_byte(LenB0)};
            src_ptr = {s_word, 1'b0};
            dst_ptr = {d_word, 1'b0};
            left_cnt = {22'(n_words) + 22'd1, 1'b0};
            if (in_bounds()) begin
              copy_on = 1'b1;
              r.fetch_valid = 1'b1;
              r.fetch_address = src_ptr;
            end else begin
              r.dma_abort = 1'b1;
            end
          end
        end
      end
      CmdByte: begin
        if (copy_on) begin
          r.write_valid = 1'b1;
          r.write_address = dst_ptr[WaddrW-1:0];
          r.write_data = data;
          src_ptr = src_ptr + SrcW'(1);
          dst_ptr = dst_ptr + DstW'(1);
          left_cnt = left_cnt - LeftW'(1);
          if (left_cnt == '0) begin
            copy_on = 1'b0;
          end else if (in_bounds()) begin
            r.fetch_valid = 1'b1;
            r.fetch_address = src_ptr;
          end else begin
            copy_on = 1'b0;
            r.dma_abort = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.dma_busy = copy_on;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Drives the request channel and the response ready at the falling edge.
  always @(negedge clk_i) begin : driver
    logic calm;
    logic hold_req;
    logic hold_rsp;
    calm = (taken_cnt >= 700) && (taken_cnt < 1000);
    hold_req = !calm && ($urandom_range(99) < 19);
    hold_rsp = !calm && ($urandom_range(99) < 19);
    if (rst_ni && !req_open && req_backlog.size() > 0 && !hold_req) req_open = 1'b1;
    req_if.valid <= req_open;
    if (req_open) begin
      req_if.cmd <= req_backlog[0].cmd;
      req_if.reg_offset <= req_backlog[0].reg_offset;
      req_if.reg_data <= req_backlog[0].reg_data;
    end
    rsp_if.ready <= !hold_rsp;
  end

  // Checks each response transaction, then predicts for each request transaction.
  always @(posedge clk_i) begin : monitor
    engine_rsp_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (due_rsp.size() == 0) begin
          $error("response transaction with none awaited");
          fail_count++;
        end else begin
          want = due_rsp.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(rsp_if.read_data));
          check_field("fetch_valid", 32'(want.fetch_valid), 32'(rsp_if.fetch_valid));
          check_field("fetch_address", 32'(want.fetch_address), 32'(rsp_if.fetch_address));
          check_field("write_valid", 32'(want.write_valid), 32'(rsp_if.write_valid));
          check_field("write_address", 32'(want.write_address), 32'(rsp_if.write_address));
          check_field("write_data", 32'(want.write_data), 32'(rsp_if.write_data));
          check_field("dma_busy", 32'(want.dma_busy), 32'(rsp_if.dma_busy));
          check_field("dma_abort", 32'(want.dma_abort), 32'(rsp_if.dma_abort));
        end
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        due_rsp.push_back(engine_step(req_if.cmd, req_if.reg_offset, req_if.reg_data));
        req_backlog.delete(0);
        req_open = 1'b0;
        taken_cnt++;
      end
      stuck_cnt = moved ? 0 : stuck_cnt + 1;
      if (stuck_cnt >= StuckLimit) begin
        $display("tb_video_register_dma_engine_top: FAIL");
        $finish;
      end
    end
  end

  task automatic push_item(logic [CmdW-1:0] cmd, logic [OffW-1:0] off, logic [ByteW-1:0] data);
    item_t it;
    it.cmd = cmd;
    it.reg_offset = off;
    it.reg_data = data;
    req_backlog.push_back(it);
  endtask

  // Programs source, destination and length, then writes the start bit.
  task automatic push_copy(logic [23:0] s_word, logic [23:0] d_word, logic [LenW-1:0] n_words,
                           logic [1:0] top);
    logic [63:0] image;
    image = {n_words[15:0], d_word, s_word};
    for (int unsigned slot = 0; slot < ParamCount; slot++) begin
      push_item(CmdWrite, param_off(slot), image[8*slot +: 8]);
    end
    push_item(CmdWrite, StartOffset, {top, 1'b1, n_words[20:16]});
  endtask

  task automatic push_noise();
    int unsigned pick;
    logic [OffW-1:0] off;
    logic [ByteW-1:0] data;
    pick = $urandom_range(99);
    off = OffW'($urandom_range(255));
    data = ByteW'($urandom_range(255));
    if (pick < 40) begin
      push_item(CmdRead, off, data);
    end else if (pick < 70) begin
      // Stray writes never start a copy, so lengths stay bounded.
      if (off == StartOffset) data[StartBit] = 1'b0;
      push_item(CmdWrite, off, data);
    end else if (pick < 85) begin
      push_item(CmdByte, off, data);
    end else begin
      push_item(CmdReserved, off, data);
    end
  endtask

  // Mostly complete copies with random addresses near and away from the bounds.
  task automatic push_random_job();
    logic [24:0] half;
    logic [23:0] s_word;
    logic [23:0] d_word;
    logic [LenW-1:0] n_words;
    int unsigned span;
    if ($urandom_range(99) >= 80) begin
      repeat ($urandom_range(6, 1)) push_noise();
      return;
    end
    half = rom_lim[RomLimitW-1:1];
    span = (half > 25'h1000000) ? 32'h1000000 : 32'(half);
    case ($urandom_range(3))
      0, 1: s_word = (span == 0) ? '0 : 24'($urandom_range(span - 1, 0));
      2: s_word = (span < 3) ? '0 : 24'(span - $urandom_range(3));
      default: s_word = 24'($urandom);
    endcase
    case ($urandom_range(3))
      0, 1: d_word = 24'($urandom_range(32'hfffff, 0));
      2: d_word = 24'h100000 - 24'($urandom_range(3));
      default: d_word = 24'($urandom);
    endcase
    n_words = ($urandom_range(9) == 0) ? LenW'($urandom_range(40)) : LenW'($urandom_range(3));
    push_copy(s_word, d_word, n_words, 2'($urandom_range(3)));
    repeat (2 * (n_words + 1)) begin
      if ($urandom_range(99) < 12) push_noise();
      push_item(CmdByte, OffW'($urandom_range(255)), ByteW'($urandom_range(255)));
    end
  endtask

  // Waits for all responses and lets any running copy finish.
  task automatic settle();
    wait (req_backlog.size() == 0 && !req_open && due_rsp.size() == 0);
    while (copy_on) begin
      repeat ((left_cnt > 64) ? 64 : left_cnt) begin
        push_item(CmdByte, '0, ByteW'($urandom_range(255)));
      end
      wait (req_backlog.size() == 0 && !req_open && due_rsp.size() == 0);
    end
  endtask

  // Writes rom_limit over the configuration port and reads it back.
  task automatic set_rom_limit(logic [RomLimitW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RomLimitAddr;
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rom_lim = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", 32'(value), prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [RomLimitW-1:0] lim;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    req_if.valid = 1'b0;
    req_if.cmd = '0;
    req_if.reg_offset = '0;
    req_if.reg_data = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Register edges, ignored commands and a start that aborts on a zero limit.
    push_item(CmdWrite, OffW'(RegCount - 1), 8'hff);
    push_item(CmdRead, OffW'(RegCount - 1), 8'h00);
    push_item(CmdWrite, 8'h00, 8'hff);
    push_item(CmdRead, 8'h00, 8'h00);
    push_item(CmdRead, 8'h01, 8'h00);
    push_item(CmdWrite, OffW'(RegCount), 8'h55);
    push_item(CmdRead, 8'hff, 8'h00);
    push_item(CmdReserved, 8'hff, 8'hff);
    push_item(CmdByte, 8'h00, 8'hff);
    push_item(CmdWrite, StartOffset, 8'(1 << StartBit));
    settle();

    // Source wraps at its top; a write during the copy is dropped.
    set_rom_limit(26'h3ffffff);
    push_item(CmdWrite, param_off(SrcB0), 8'hff);
    push_item(CmdWrite, param_off(SrcB1), 8'hff);
    push_item(CmdWrite, param_off(SrcB2), 8'hff);
    push_item(CmdWrite, param_off(LenB0), 8'h01);
    push_item(CmdWrite, StartOffset, 8'(1 << StartBit));
    push_item(CmdByte, 8'h00, 8'h00);
    push_item(CmdWrite, StartOffset, 8'hff);
    push_item(CmdByte, 8'hff, 8'hff);
    push_item(CmdRead, StartOffset, 8'h00);
    push_item(CmdByte, 8'h00, 8'h5a);
    push_item(CmdByte, 8'h00, 8'ha5);

    // Longest length with the destination just under its bound aborts mid-copy.
    push_item(CmdWrite, param_off(DstB0), 8'hff);
    push_item(CmdWrite, param_off(DstB1), 8'hff);
    push_item(CmdWrite, param_off(DstB2), 8'h0f);
    push_item(CmdWrite, param_off(LenB0), 8'hff);
    push_item(CmdWrite, param_off(LenB1), 8'hff);
    push_item(CmdWrite, StartOffset, 8'hff);
    push_item(CmdByte, 8'h00, 8'h00);
    push_item(CmdByte, 8'hff, 8'hff);
    settle();

    // Random phases, each under its own ROM limit.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: lim = RomLimitW'($urandom_range(32'hffff, 1));
        1: lim = 26'h2000000;
        2: lim = RomLimitW'($urandom);
        3: lim = 26'h0;
        4: lim = 26'h3ffffff;
        default: lim = 26'h10000;
      endcase
      set_rom_limit(lim);
      while (req_backlog.size() < 330) push_random_job();
      settle();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_video_register_dma_engine_top: PASS");
    end else begin
      $display("tb_video_register_dma_engine_top: FAIL");
    end
    $finish;
  end

endmodule
